FILE: rtl/allpass_fractional_delay_line_top_macros.svh
// Assertion helpers for the allpass delay line. They sample on clk and are
// quiet while arst_n is low.
`ifndef ALLPASS_FRACTIONAL_DELAY_LINE_TOP_MACROS_SVH
`define ALLPASS_FRACTIONAL_DELAY_LINE_TOP_MACROS_SVH

// same-cycle implication
`define APFD_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("apfd check failed");

// next-cycle implication
`define APFD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("apfd check failed");

`endif

FILE: rtl/apfd_pkg.sv
`default_nettype none

package apfd_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int LAG_W = 27;

	// Q16 lag arithmetic
	localparam int FRAC_W = 16;
	localparam int ONE_Q16 = 65536;
	localparam int LAG_MIN_Q16 = 6554;

	// coefficient is Q1.15, quotient of the coefficient divide fits in 16 bits
	localparam int COEF_FRAC = 15;
	localparam int QUOT_W = 16;

	// default store depth
	localparam int DELAY_LENGTH_DEF = 2048;

	// lag write sequencer
	typedef enum logic [2:0] {
		CFG_IDLE,
		CFG_POS,
		CFG_FRAC,
		CFG_PREP,
		CFG_DIV
	} cfg_state_t;

endpackage

`default_nettype wire

FILE: rtl/allpass_fractional_delay_line_top.sv
`default_nettype none

// Allpass-interpolated fractional delay line. Each sample_in transfer is written
// into a circular store of DELAY_LENGTH entries; the entry at the trailing read
// position passes through a first-order allpass y = c*(xd - y_prev) + xd_prev,
// rounded and saturated to Q1.15. Throughput is one sample per clock unless
// out_stall or a lag write holds input off: the store is one synchronous memory
// with one write and one read port, and the allpass feedback (one 16x17 multiply,
// add, saturate) is combinational. sample_out is registered behind a stage that
// holds the store read. A write to delay_lag (Q16 samples, clamped to
// [0.1, DELAY_LENGTH-1]) places the read position, forms the fraction, sets up
// and runs a restoring divide for the coefficient; cfg_ready is low and sample
// input is stalled for that time. No clearing pass is run after reset: a fill
// count makes unwritten entries read as zero. Reset leaves the coefficient at
// zero and the read position at half the store until delay_lag is first written.
module allpass_fractional_delay_line_top
	import apfd_pkg::*;
#(
	parameter int DELAY_LENGTH = DELAY_LENGTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// sample input
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	// sample output
	output      logic signed [SAMPLE_W-1:0] sample_out,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	// lag register write
	input  wire logic [LAG_W-1:0]           delay_lag,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready
);

	localparam int AW = $clog2(DELAY_LENGTH);
	localparam int PW = AW + FRAC_W;
	localparam int CW = (PW > LAG_W) ? PW : LAG_W;
	localparam int QCW = $clog2(QUOT_W);
	localparam logic [CW-1:0] LagMax = CW'(DELAY_LENGTH - 1) << FRAC_W;
	localparam logic [CW-1:0] LagMin = CW'(LAG_MIN_Q16);
	localparam logic [17:0] One18 = 18'(ONE_Q16);

	function automatic logic [AW-1:0] adv_pos(input logic [AW-1:0] pos);
		return (pos == AW'(DELAY_LENGTH - 1)) ? '0 : pos + 1'b1;
	endfunction

	// ---------------- lag write sequencer ----------------
	cfg_state_t         cfg_state_q, cfg_state_d;
	logic               cfg_acc;
	logic [QCW-1:0]     cnt_q;
	logic [PW-1:0]      lag_q;
	logic [PW-1:0]      p_q;
	logic [17:0]        alpha_q;
	logic [17:0]        den_q;
	logic               neg_q;
	logic [17:0]        rem_q;
	logic [QUOT_W-1:0]  dlo_q;
	logic [QUOT_W-1:0]  quot_q;
	logic signed [SAMPLE_W-1:0] coeff_q;
	logic [AW-1:0]      wr_pos_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_state_q <= CFG_IDLE;
		end else begin
			cfg_state_q <= cfg_state_d;
		end
	end

	// next state
	always_comb begin
		cfg_state_d = cfg_state_q;
		cfg_ready = 1'b0;
		unique case (cfg_state_q)
			CFG_IDLE: begin
				cfg_ready = 1'b1;
				if (cfg_valid) cfg_state_d = CFG_POS;
			end
			CFG_POS:  cfg_state_d = CFG_FRAC;
			CFG_FRAC: cfg_state_d = CFG_PREP;
			CFG_PREP: cfg_state_d = CFG_DIV;
			CFG_DIV: begin
				if (cnt_q == '0) cfg_state_d = CFG_IDLE;
			end
			default: cfg_state_d = CFG_IDLE;
		endcase
	end

	assign cfg_acc = cfg_valid && cfg_ready;

	// clamp on write
	logic [CW-1:0] lag_ext;
	logic [CW-1:0] lag_clamp;
	always_comb begin
		lag_ext = CW'(delay_lag);
		if (lag_ext > LagMax) lag_clamp = LagMax;
		else if (lag_ext < LagMin) lag_clamp = LagMin;
		else lag_clamp = lag_ext;
	end

	// read point in Q16: (wr+1) - lag, wrapped once when negative
	logic [AW:0]        wr_inc;
	logic signed [PW+1:0] p_raw;
	logic signed [PW+1:0] p_wrap;
	always_comb begin
		wr_inc = (AW + 1)'(wr_pos_q) + 1'b1;
		p_raw = $signed({1'b0, wr_inc, {FRAC_W{1'b0}}}) - $signed((PW + 2)'(lag_q));
		p_wrap = p_raw[PW+1] ? p_raw + $signed((PW + 2)'(DELAY_LENGTH) << FRAC_W) : p_raw;
	end

	// fraction to alpha; small alpha moves the read point one slot on
	logic [17:0]   alpha0;
	logic          alpha_small;
	logic [AW-1:0] rp_int;
	always_comb begin
		alpha0 = One18 - 18'(p_q[FRAC_W-1:0]);
		alpha_small = alpha0 < 18'(LAG_MIN_Q16);
		rp_int = p_q[PW-1:FRAC_W];
	end

	// divide setup: |1-alpha| * 2^15 + den/2 over den = 1+alpha
	logic        num_neg;
	logic [16:0] num_mag;
	logic [17:0] den_c;
	logic [31:0] dividend;
	always_comb begin
		num_neg = alpha_q > One18;
		num_mag = num_neg ? 17'(alpha_q - One18) : 17'(One18 - alpha_q);
		den_c = One18 + alpha_q;
		dividend = (32'(num_mag) << COEF_FRAC) + 32'(den_c >> 1);
	end

	// one restoring divide step
	logic [18:0]       rem_sh;
	logic              qbit;
	logic [QUOT_W-1:0] quot_nx;
	always_comb begin
		rem_sh = {rem_q, dlo_q[QUOT_W-1]};
		qbit = rem_sh >= 19'(den_q);
		quot_nx = {quot_q[QUOT_W-2:0], qbit};
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		if (cfg_acc) lag_q <= PW'(lag_clamp);
		unique case (cfg_state_q)
			CFG_POS: p_q <= PW'(p_wrap);
			CFG_FRAC: alpha_q <= alpha_small ? alpha0 + One18 : alpha0;
			CFG_PREP: begin
				den_q <= den_c;
				neg_q <= num_neg;
				rem_q <= 18'(dividend[31:QUOT_W]);
				dlo_q <= dividend[QUOT_W-1:0];
				cnt_q <= QCW'(QUOT_W - 1);
			end
			CFG_DIV: begin
				rem_q <= qbit ? 18'(rem_sh - 19'(den_q)) : rem_sh[17:0];
				dlo_q <= dlo_q << 1;
				quot_q <= quot_nx;
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// coefficient, zero until the first lag write completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_state_q == CFG_DIV && cnt_q == '0) begin
			coeff_q <= neg_q ? -$signed(quot_nx) : $signed(quot_nx);
		end
	end

	// ---------------- sample path ----------------
	logic [AW-1:0] rd_pos_q;
	logic [AW:0]   fill_q;
	logic          in_acc;
	logic          s1_valid_q;
	logic          s1_move;
	logic          out_valid_q;

	assign s1_move = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = (cfg_state_q != CFG_IDLE) || cfg_valid || (s1_valid_q && !s1_move);
	assign in_acc = in_valid && !in_stall;

	// positions and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
			rd_pos_q <= AW'(DELAY_LENGTH / 2);
			fill_q <= '0;
		end else begin
			if (in_acc) begin
				wr_pos_q <= adv_pos(wr_pos_q);
				rd_pos_q <= adv_pos(rd_pos_q);
				if (fill_q != (AW + 1)'(DELAY_LENGTH)) fill_q <= fill_q + 1'b1;
			end else if (cfg_state_q == CFG_FRAC) begin
				rd_pos_q <= alpha_small ? adv_pos(rp_int) : rp_int;
			end
		end
	end

	// delay store: write the new sample, read the trailing one
	logic signed [SAMPLE_W-1:0] store_mem [DELAY_LENGTH];
	logic signed [SAMPLE_W-1:0] rdata_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic                       fwd_s1;
	logic                       vld_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			store_mem[wr_pos_q] <= sample_in;
			rdata_s1 <= store_mem[rd_pos_q];
			x_s1 <= sample_in;
			fwd_s1 <= rd_pos_q == wr_pos_q;
			vld_s1 <= (AW + 1)'(rd_pos_q) < fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_acc || (s1_valid_q && !s1_move);
			out_valid_q <= s1_move || (out_valid_q && out_stall);
		end
	end

	// allpass: c*(xd - y_prev) + xd_prev, round half up, saturate
	logic signed [SAMPLE_W-1:0] prev_out_q;
	logic signed [SAMPLE_W-1:0] prev_dly_q;
	logic signed [SAMPLE_W-1:0] xd;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [2*SAMPLE_W:0] prod;
	logic signed [2*SAMPLE_W+1:0] acc;
	logic signed [SAMPLE_W+2:0] ysh;
	logic signed [SAMPLE_W-1:0] ysat;
	always_comb begin
		if (fwd_s1) xd = x_s1;
		else if (vld_s1) xd = rdata_s1;
		else xd = '0;
		diff = (SAMPLE_W + 1)'(xd) - (SAMPLE_W + 1)'(prev_out_q);
		prod = (2 * SAMPLE_W + 1)'(coeff_q) * (2 * SAMPLE_W + 1)'(diff);
		acc = (2 * SAMPLE_W + 2)'(prod) + ((2 * SAMPLE_W + 2)'(prev_dly_q) <<< COEF_FRAC)
			+ (2 * SAMPLE_W + 2)'(signed'(1 << (COEF_FRAC - 1)));
		ysh = (SAMPLE_W + 3)'(acc >>> COEF_FRAC);
		if (ysh > (SAMPLE_W + 3)'(signed'(32767))) ysat = 16'sh7FFF;
		else if (ysh < -(SAMPLE_W + 3)'(signed'(32768))) ysat = 16'sh8000;
		else ysat = SAMPLE_W'(ysh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_out_q <= '0;
			prev_dly_q <= '0;
		end else if (s1_move) begin
			prev_out_q <= ysat;
			prev_dly_q <= xd;
		end
	end

	// output register
	logic signed [SAMPLE_W-1:0] sample_out_q;
	always_ff @(posedge clk) begin
		if (s1_move) sample_out_q <= ysat;
	end

	assign sample_out = sample_out_q;
	assign out_valid = out_valid_q;

	// ---------------- checks ----------------
`include "allpass_fractional_delay_line_top_macros.svh"

	`APFD_ASSERT_NEXT(a_s1_held, s1_valid_q && !s1_move, s1_valid_q && $stable(x_s1))
	`APFD_ASSERT_NEXT(a_fill_idle, !in_acc, $stable(fill_q))
	`APFD_ASSERT_NOW(a_fill_max, 1'b1, fill_q <= (AW + 1)'(DELAY_LENGTH))
	`APFD_ASSERT_NEXT(a_div_end, cfg_state_q == CFG_DIV && cnt_q == '0, cfg_state_q == CFG_IDLE)
	`APFD_ASSERT_NOW(a_no_item_in_cfg, cfg_state_q != CFG_IDLE, !in_acc)

endmodule

`default_nettype wire

FILE: tb/apfd_output_checker.sv
`default_nettype none

// Watches the sample, output and lag channels of the delay line, keeps its own
// model of the store and allpass, and compares every output transfer with the
// oldest predicted sample.
module apfd_output_checker
	import apfd_pkg::*;
#(
	parameter int DEPTH = DELAY_LENGTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample_out,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic [LAG_W-1:0]           delay_lag,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	output int                              mismatches,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW = $clog2(DEPTH);
	localparam longint SAT_HI = 2 ** (SAMPLE_W - 1) - 1;
	localparam longint SAT_LO = -(2 ** (SAMPLE_W - 1));
	localparam int REPORT_LIMIT = 10;

	// model state
	logic signed [SAMPLE_W-1:0] line_mem [DEPTH];
	logic [AW-1:0]              wr_ptr;
	logic [AW-1:0]              rd_ptr;
	longint                     coef;
	longint                     last_tap;
	longint                     last_out;

	logic signed [SAMPLE_W-1:0] expected_samples [$];
	logic signed [SAMPLE_W-1:0] want;
	int                         err_total;

	function automatic logic [AW-1:0] next_slot(logic [AW-1:0] slot);
		return (slot == AW'(DEPTH - 1)) ? '0 : slot + 1'b1;
	endfunction

	// lag write: place the read tap behind the write pointer, derive the coefficient
	function automatic void set_lag(logic [LAG_W-1:0] lag_word);
		longint lag, pos, alpha, num, den, mag, quot;
		lag = longint'(lag_word);
		if (lag > longint'(DEPTH - 1) * ONE_Q16) lag = longint'(DEPTH - 1) * ONE_Q16;
		if (lag < LAG_MIN_Q16) lag = LAG_MIN_Q16;
		pos = (longint'(wr_ptr) + 1) * ONE_Q16 - lag;
		if (pos < 0) pos += longint'(DEPTH) * ONE_Q16;
		rd_ptr = AW'((pos / ONE_Q16) % DEPTH);
		alpha = ONE_Q16 - (pos % ONE_Q16);
		// fraction under 0.1: step one slot and stretch alpha past one
		if (alpha < LAG_MIN_Q16) begin
			rd_ptr = next_slot(rd_ptr);
			alpha += ONE_Q16;
		end
		num = ONE_Q16 - alpha;
		den = ONE_Q16 + alpha;
		mag = ((num < 0) ? -num : num) * (longint'(1) << COEF_FRAC);
		quot = (mag + den / 2) / den;
		coef = (num < 0) ? -quot : quot;
	endfunction

	// one sample through the store and the allpass
	function automatic logic signed [SAMPLE_W-1:0] allpass_next(
		logic signed [SAMPLE_W-1:0] x
	);
		longint tap, acc, y;
		line_mem[wr_ptr] = x;
		wr_ptr = next_slot(wr_ptr);
		tap = longint'(line_mem[rd_ptr]);
		rd_ptr = next_slot(rd_ptr);
		acc = coef * (tap - last_out) + last_tap * (longint'(1) << COEF_FRAC)
			+ (longint'(1) << (COEF_FRAC - 1));
		y = acc >>> COEF_FRAC;
		if (y > SAT_HI) y = SAT_HI;
		if (y < SAT_LO) y = SAT_LO;
		last_out = y;
		last_tap = tap;
		return SAMPLE_W'(y);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_mem[i] = '0;
			wr_ptr = '0;
			rd_ptr = AW'(DEPTH / 2);
			coef = 0;
			last_tap = 0;
			last_out = 0;
			expected_samples.delete();
			err_total = 0;
		end else begin
			// output side first: it always belongs to an older input
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					err_total++;
					if (err_total <= REPORT_LIMIT)
						$display("%t: unexpected sample_out %0d, nothing pending",
							$realtime, sample_out);
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want) begin
						err_total++;
						if (err_total <= REPORT_LIMIT)
							$display("%t: sample_out expected %0d, got %0d",
								$realtime, want, sample_out);
					end
				end
			end
			if (cfg_valid && cfg_ready) set_lag(delay_lag);
			if (in_valid && !in_stall) expected_samples.push_back(allpass_next(sample_in));
		end
		mismatches <= err_total;
		pending <= expected_samples.size();
	end

endmodule

`default_nettype wire

FILE: tb/allpass_fractional_delay_line_top_test.sv
`default_nettype none

module allpass_fractional_delay_line_top_test;
	import apfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 150;

	logic                       clk;
	logic                       arst_n;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       out_valid;
	logic                       out_stall;
	logic [LAG_W-1:0]           delay_lag;
	logic                       cfg_valid;
	logic                       cfg_ready;

	int idle_pct;
	int stall_pct;
	int mismatches;
	int pending;

	allpass_fractional_delay_line_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_out (sample_out),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.delay_lag  (delay_lag),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready)
	);

	apfd_output_checker #(
		.DEPTH (DELAY_LENGTH_DEF)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_out (sample_out),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.delay_lag  (delay_lag),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop
	initial begin
		#20ms;
		$display("allpass_fractional_delay_line_top_test failed");
		$finish;
	end

	// output side backpressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// one sample transfer, with random idle cycles ahead of it
	task automatic push_sample(input logic signed [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// lag write once the pipe has drained
	task automatic write_lag(input logic [LAG_W-1:0] lag);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		delay_lag <= lag;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [LAG_W-1:0] pick_lag();
		case ($urandom_range(5))
			0: return LAG_W'($urandom);
			1: return LAG_W'($urandom_range(LAG_MIN_Q16 + 300));
			2: return LAG_W'(ONE_Q16 * $urandom_range(1, 16));
			// fractions near the slot-step threshold
			3: return LAG_W'(ONE_Q16 * $urandom_range(1, 16) + $urandom_range(7000));
			default: return LAG_W'($urandom_range(40 * ONE_Q16));
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return $urandom_range(1) ? {1'b0, {(SAMPLE_W - 1){1'b1}}}
				: {1'b1, {(SAMPLE_W - 1){1'b0}}};
			1: return SAMPLE_W'(int'($urandom_range(64)) - 32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		out_stall = 1'b0;
		delay_lag = '0;
		cfg_valid = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficient and tap position, no lag written yet
		push_sample(16'sh7fff);
		push_sample(-16'sh8000);
		push_sample(16'sh0000);
		push_sample(-16'sh0001);

		// below minimum lag, clamps to 0.1; runs of extremes drive saturation
		write_lag('0);
		push_sample(16'sh7fff);
		push_sample(16'sh7fff);
		push_sample(-16'sh8000);
		push_sample(-16'sh8000);
		push_sample(16'sh7fff);
		push_sample(16'sh7fff);

		// lag of exactly one: tap reads the sample just written
		write_lag(LAG_W'(ONE_Q16));
		push_sample(16'sh3039);
		push_sample(-16'sh0001);
		push_sample(16'sh0000);

		// full register word, clamps to the top
		write_lag('1);
		push_sample(16'sh5555);
		push_sample(-16'sh5556);

		// exact top of range
		write_lag(LAG_W'((DELAY_LENGTH_DEF - 1) * ONE_Q16));
		push_sample(16'sh0001);

		// one below the minimum
		write_lag(LAG_W'(LAG_MIN_Q16 - 1));
		push_sample(-16'sh8000);

		// fraction under 0.1: slot step and negative coefficient
		write_lag(LAG_W'(ONE_Q16 + 3277));
		push_sample(16'sh7fff);
		push_sample(-16'sh8000);

		// half sample fraction
		write_lag(LAG_W'(2 * ONE_Q16 + ONE_Q16 / 2));
		push_sample(16'sh1234);
		push_sample(-16'sh4321);

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < PHASES; ph++) begin
			write_lag(pick_lag());
			idle_pct <= (ph % 4 == 1) ? 85 : (ph % 4 == 3) ? 15 : 0;
			stall_pct <= (ph % 4 == 2) ? 85 : (ph % 4 == 3) ? 15 : 0;
			repeat (PHASE_ITEMS) push_sample(pick_sample());
		end

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("allpass_fractional_delay_line_top_test passed");
		end else begin
			$display("allpass_fractional_delay_line_top_test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
